@@ rtl/core/arbe_pkg.sv @@
// ----------------------------------------------------------------------------
// arbe_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the averaged report-by-exception block.
// ----------------------------------------------------------------------------
package arbe_pkg;

   // Default number of redundant sensors per round.
   localparam int MAX_SOURCES_DEF = 8;

   // Field widths.
   localparam int READING_W = 32;
   localparam int TIME_W    = 32;
   localparam int DELTA_W   = 31;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DELTA      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BEACON_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_FORCES    = 2'd2;

   // Register reset values.
   localparam logic [DELTA_W-1:0] MIN_DELTA_RST = 31'd256;

   // Packed channel widths (whole bytes).
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // a request is taken this cycle
      logic setup;    // load the divider from the round totals
      logic step;     // one restoring division step
      logic sign;     // apply the sign to the quotient
      logic load;     // decide, update report state, load the response
   } arbe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_full; // the response register cannot take a new result
   } arbe_sts_type;

endpackage

@@ rtl/core/arbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// arbe_ctrl
// Round sequencer: takes requests, then steps the datapath through the
// division, sign fix and publish decision at the end of each round.
// ----------------------------------------------------------------------------
module arbe_ctrl #(
   parameter int DIV_STEPS = 35
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  arbe_pkg::arbe_sts_type sts,
   output arbe_pkg::arbe_cmd_type cmd
);
   import arbe_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_SIGN,
      ST_REPORT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              accept;

   // Requests are taken only while no round is being closed.
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Command decode.
   assign cmd.accept = accept;
   assign cmd.setup  = (state_ff == ST_SETUP);
   assign cmd.step   = (state_ff == ST_DIVIDE);
   assign cmd.sign   = (state_ff == ST_SIGN);
   assign cmd.load   = (state_ff == ST_REPORT) && !sts.rsp_full;

   // State and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_tlast) begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               step_ff  <= STEP_W'(DIV_STEPS - 1);
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (step_ff == '0) begin
                  state_ff <= ST_SIGN;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_SIGN: begin
               state_ff <= ST_REPORT;
            end
            ST_REPORT: begin
               if (!sts.rsp_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A result is never loaded over one that is still waiting.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !sts.rsp_full)
      else $error("response loaded while the response register is full");

   // No request is taken while a round is being closed.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.setup || cmd.step || cmd.sign) |-> !cmd.accept)
      else $error("request accepted during end-of-round processing");

   // The division always runs its full length before the sign fix.
   a_divide_then_sign: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && step_ff == '0) |=> cmd.sign)
      else $error("sign step did not follow the last division step");

endmodule

@@ rtl/core/arbe_datapath.sv @@
// ----------------------------------------------------------------------------
// arbe_datapath
// Round accumulator, bit-serial divider, publish decision, report state,
// configuration registers and the response register.
// ----------------------------------------------------------------------------
module arbe_datapath #(
   parameter int MAX_SOURCES = arbe_pkg::MAX_SOURCES_DEF,
   parameter int SUM_W       = 35
) (
   input  logic                              clock,
   input  logic                              reset,
   input  arbe_pkg::arbe_cmd_type            cmd,
   output arbe_pkg::arbe_sts_type            sts,
   input  logic signed [arbe_pkg::READING_W-1:0] reading,
   input  logic                              reading_valid,
   input  logic [arbe_pkg::TIME_W-1:0]       now_ms,
   input  logic                              link_ready,
   input  logic                              csr_we,
   input  logic [arbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arbe_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic signed [arbe_pkg::READING_W-1:0] rsp_average,
   output logic                              rsp_average_valid,
   output logic                              rsp_publish,
   output logic signed [arbe_pkg::READING_W-1:0] rsp_reported_value,
   output logic                              rsp_reported_valid
);
   import arbe_pkg::*;

   localparam int CNT_W = $clog2(MAX_SOURCES + 1);

   // Configuration registers.
   logic [DELTA_W-1:0]   min_delta_ff;
   logic [TIME_W-1:0]    beacon_timeout_ff;
   logic                 zero_forces_ff;

   // Round totals and the end-of-round request fields.
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [TIME_W-1:0]       now_ff;
   logic                    link_ff;

   // Divider.
   logic [CNT_W-1:0]        rem_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic                    neg_ff;
   logic [CNT_W:0]          trial;
   logic                    trial_ge;
   logic [CNT_W-1:0]        rem_in;
   logic [SUM_W-1:0]        quo_in;
   logic signed [READING_W-1:0] avg_ff;

   // Report state.
   logic signed [READING_W-1:0] last_rep_ff;
   logic                        last_rep_valid_ff;
   logic [TIME_W-1:0]           last_time_ff;

   // Decision.
   logic signed [READING_W:0] diff;
   logic [READING_W:0]        diff_abs;
   logic [TIME_W-1:0]         elapsed;
   logic                      round_valid;
   logic                      want;
   logic                      pub;

   // Response register.
   logic                        rsp_valid_ff;
   logic signed [READING_W-1:0] rsp_avg_ff;
   logic                        rsp_avg_valid_ff;
   logic                        rsp_pub_ff;
   logic signed [READING_W-1:0] rsp_rep_ff;
   logic                        rsp_rep_valid_ff;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_delta_ff      <= MIN_DELTA_RST;
         beacon_timeout_ff <= '0;
         zero_forces_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_DELTA:      min_delta_ff      <= csr_data[DELTA_W-1:0];
            REG_BEACON_TIMEOUT: beacon_timeout_ff <= csr_data[TIME_W-1:0];
            REG_ZERO_FORCES:    zero_forces_ff    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Accumulate valid readings; the count saturates at the number of sources.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.load) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.accept && reading_valid
                   && (count_ff < CNT_W'(MAX_SOURCES))) begin
         sum_ff   <= sum_ff + SUM_W'(reading);
         count_ff <= count_ff + 1'b1;
      end
   end

   // The time and link state of the closing request.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         now_ff  <= now_ms;
         link_ff <= link_ready;
      end
   end

   // Restoring division step on the magnitude of the sum.
   always_comb begin
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      trial_ge = (trial >= {1'b0, count_ff});
      if (trial_ge) begin
         rem_in = CNT_W'(trial - {1'b0, count_ff});
      end else begin
         rem_in = CNT_W'(trial);
      end
      quo_in = {quo_ff[SUM_W-2:0], trial_ge};
   end

   // Divider registers and signed, truncated quotient.
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         rem_ff <= '0;
         neg_ff <= sum_ff[SUM_W-1];
         if (sum_ff[SUM_W-1]) begin
            quo_ff <= SUM_W'(-sum_ff);
         end else begin
            quo_ff <= SUM_W'(sum_ff);
         end
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.sign) begin
         if (neg_ff) begin
            avg_ff <= -$signed(quo_ff[READING_W-1:0]);
         end else begin
            avg_ff <= $signed(quo_ff[READING_W-1:0]);
         end
      end
   end

   // Publish decision.
   always_comb begin
      round_valid = (count_ff != '0);
      diff        = $signed({last_rep_ff[READING_W-1], last_rep_ff})
                  - $signed({avg_ff[READING_W-1], avg_ff});
      diff_abs    = diff[READING_W] ? (READING_W+1)'(-diff) : (READING_W+1)'(diff);
      elapsed     = now_ff - last_time_ff;
      want        = !last_rep_valid_ff
                  || (diff_abs > {2'b00, min_delta_ff})
                  || (zero_forces_ff && (avg_ff == '0) && (last_rep_ff != '0))
                  || ((beacon_timeout_ff != '0) && (elapsed > beacon_timeout_ff));
      pub         = round_valid && want && link_ff;
   end

   // Report state update at the close of a round.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_rep_ff       <= '0;
         last_rep_valid_ff <= 1'b0;
         last_time_ff      <= '0;
      end else if (cmd.load) begin
         if (!round_valid) begin
            last_rep_ff       <= '0;
            last_rep_valid_ff <= 1'b0;
         end else if (pub) begin
            last_rep_ff       <= avg_ff;
            last_rep_valid_ff <= 1'b1;
            last_time_ff      <= now_ff;
         end
      end
   end

   // Response register; a new result may be loaded as the old one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_avg_ff       <= round_valid ? avg_ff : '0;
         rsp_avg_valid_ff <= round_valid;
         rsp_pub_ff       <= pub;
         if (!round_valid) begin
            rsp_rep_ff       <= '0;
            rsp_rep_valid_ff <= 1'b0;
         end else if (pub) begin
            rsp_rep_ff       <= avg_ff;
            rsp_rep_valid_ff <= 1'b1;
         end else begin
            rsp_rep_ff       <= last_rep_ff;
            rsp_rep_valid_ff <= last_rep_valid_ff;
         end
      end
   end

   assign sts.rsp_full        = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_average         = rsp_avg_ff;
   assign rsp_average_valid   = rsp_avg_valid_ff;
   assign rsp_publish         = rsp_pub_ff;
   assign rsp_reported_value  = rsp_rep_ff;
   assign rsp_reported_valid  = rsp_rep_valid_ff;

   // The source count never passes the number of sources.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SOURCES))
      else $error("source count exceeded the number of sources");

   // A loaded result is presented in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded response not presented");

   // A published result carries its own average as the reported value.
   a_pub_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pub_ff) |->
         (rsp_rep_valid_ff && rsp_avg_valid_ff && (rsp_rep_ff == rsp_avg_ff)))
      else $error("published result inconsistent with the reported value");

   // An empty round neither publishes nor keeps a report.
   a_empty_round: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_avg_valid_ff) |->
         (!rsp_pub_ff && !rsp_rep_valid_ff && (rsp_rep_ff == '0)))
      else $error("empty round produced a report");

endmodule

@@ rtl/core/averaged_report_by_exception_top.sv @@
// ----------------------------------------------------------------------------
// averaged_report_by_exception_top
// Averages one round of redundant sensor readings and decides whether to
// publish the average under a deadband, a drop-to-zero rule and a heartbeat.
// ----------------------------------------------------------------------------
// Each request carries one sensor reading; the request with tlast set closes
// the round and produces exactly one response, other requests produce none.
// A request that does not close a round is taken whenever the block is idle.
// Closing a round runs these steps in order: take the request, set up the
// divider, run the one-bit-per-cycle restoring divider that divides the
// round sum by the valid-reading count, apply the sign, then make the
// publish decision and load the response register, which waits there if
// the response side is stalled. New requests are held off until the round
// has been closed, but the next round may start while its response still
// waits. Configuration writes are always taken and should be made only
// while no round is in progress.
// ----------------------------------------------------------------------------
module averaged_report_by_exception_top #(
   parameter int MAX_SOURCES = arbe_pkg::MAX_SOURCES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: reading[31:0], now_ms[63:32], link_ready[64], zero fill [71:65]
   input  logic [arbe_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: reading_valid[0]
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: average[31:0], publish[32], reported_value[64:33],
   //        reported_valid[65], zero fill [71:66]
   output logic [arbe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: average_valid[0]
   output logic                               rsp_tuser,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [arbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [arbe_pkg::CSR_DATA_W-1:0]    csr_data
);
   import arbe_pkg::*;

   // Sum width: one reading plus growth for the number of sources.
   localparam int SUM_W = READING_W + $clog2(MAX_SOURCES);

   arbe_cmd_type cmd;
   arbe_sts_type sts;

   logic signed [READING_W-1:0] rsp_average;
   logic                        rsp_average_valid;
   logic                        rsp_publish;
   logic signed [READING_W-1:0] rsp_reported_value;
   logic                        rsp_reported_valid;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   arbe_ctrl #(
      .DIV_STEPS (SUM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   arbe_datapath #(
      .MAX_SOURCES (MAX_SOURCES),
      .SUM_W       (SUM_W)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .reading            ($signed(req_tdata[READING_W-1:0])),
      .reading_valid      (req_tuser),
      .now_ms             (req_tdata[READING_W+TIME_W-1:READING_W]),
      .link_ready         (req_tdata[READING_W+TIME_W]),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_average        (rsp_average),
      .rsp_average_valid  (rsp_average_valid),
      .rsp_publish        (rsp_publish),
      .rsp_reported_value (rsp_reported_value),
      .rsp_reported_valid (rsp_reported_valid)
   );

   // Response packing.
   assign rsp_tdata = {6'd0, rsp_reported_valid, rsp_reported_value,
                       rsp_publish, rsp_average};
   assign rsp_tuser = rsp_average_valid;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the averaged report-by-exception block.
// ----------------------------------------------------------------------------
// Sensor rounds are streamed into the request channel. A tracker class keeps
// its own copy of the round totals, the report state and the registers. For
// every round it predicts the response and compares the real one with it,
// field by field. A short directed part covers the extremes, the deadband
// edge, source saturation, empty rounds, a refused link, the drop-to-zero
// rule and a wrapping heartbeat. Random phases follow, each with its own
// register setting. Both channels idle at random, and in one phase the
// response side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import arbe_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES   = 60;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PHASE_ITEMS     = 205;

   // Tracks the report state and holds the responses still owed by the block.
   class report_tracker_type;
      typedef struct {
         logic signed [31:0] average;
         logic               average_valid;
         logic               publish;
         logic signed [31:0] reported_value;
         logic               reported_valid;
      } report_type;

      // Registers.
      bit [DELTA_W-1:0]  deadband;
      bit [TIME_W-1:0]   heartbeat_ms;
      bit                zero_rule;
      // Round totals and report state.
      longint            round_sum;
      int                round_count;
      bit signed [31:0]  held_value;
      bit                held_valid;
      bit [TIME_W-1:0]   held_time;

      report_type        expected_reports[$];
      int unsigned       mismatches;

      function new();
         deadband     = MIN_DELTA_RST;
         heartbeat_ms = '0;
         zero_rule    = 1'b0;
         round_sum    = 0;
         round_count  = 0;
         held_value   = '0;
         held_valid   = 1'b0;
         held_time    = '0;
         mismatches   = 0;
      endfunction

      function void apply_write(bit [CSR_IDX_W-1:0] index, bit [CSR_DATA_W-1:0] value);
         case (index)
            REG_MIN_DELTA: begin
               deadband = value[DELTA_W-1:0];
            end
            REG_BEACON_TIMEOUT: begin
               heartbeat_ms = value;
            end
            REG_ZERO_FORCES: begin
               zero_rule = value[0];
            end
            default: begin
            end
         endcase
      endfunction

      // Adds one request to the round; the closing request yields a response.
      function void note_request(bit signed [31:0] reading, bit valid, bit last,
                                 bit [TIME_W-1:0] now, bit link);
         report_type       r;
         longint           gap;
         bit [TIME_W-1:0]  elapsed;
         bit               attempt;
         if (valid && round_count < MAX_SOURCES_DEF) begin
            round_sum += reading;
            round_count++;
         end
         if (!last) return;
         r.average       = '0;
         r.average_valid = 1'b0;
         r.publish       = 1'b0;
         if (round_count == 0) begin
            // No sensor answered: the last report is forgotten.
            held_valid = 1'b0;
            held_value = '0;
         end else begin
            r.average       = 32'(round_sum / round_count);
            r.average_valid = 1'b1;
            gap = longint'(held_value) - longint'(r.average);
            if (gap < 0) gap = -gap;
            elapsed = now - held_time;
            attempt = !held_valid || gap > longint'(deadband)
                      || (zero_rule && r.average == 0 && held_value != 0)
                      || (heartbeat_ms != 0 && elapsed > heartbeat_ms);
            if (attempt && link) begin
               r.publish  = 1'b1;
               held_value = r.average;
               held_valid = 1'b1;
               held_time  = now;
            end
         end
         round_sum   = 0;
         round_count = 0;
         r.reported_value = held_value;
         r.reported_valid = held_valid;
         expected_reports = {expected_reports, r};
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, seen);
            mismatches++;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic user);
         report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: response expected none, got data %h user %b",
                     $time, data, user);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         compare("average", want.average, data[31:0]);
         compare("average_valid", 32'(want.average_valid), 32'(user));
         compare("publish", 32'(want.publish), 32'(data[32]));
         compare("reported_value", want.reported_value, data[64:33]);
         compare("reported_valid", 32'(want.reported_valid), 32'(data[65]));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   report_tracker_type     tracker;
   bit                     idling_on = 1'b0;
   logic                   hold_off_req = 1'b0;
   int unsigned            stall_cycles = 0;
   int unsigned            phase_items;
   longint                 level = 0;
   bit [TIME_W-1:0]        wall_ms = 32'd100;

   averaged_report_by_exception_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned idle_gap();
      int unsigned roll = $urandom_range(0, 99);
      if (!idling_on) return 0;
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit [31:0] saturate(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return 32'(v);
   endfunction

   // Advances the millisecond clock; large jumps make it wrap now and then.
   function automatic bit [TIME_W-1:0] next_time();
      if ($urandom_range(0, 9) == 0) wall_ms += $urandom;
      else wall_ms += $urandom_range(0, 400);
      return wall_ms;
   endfunction

   // Observe both channels and the register port at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            tracker.note_request(req_tdata[31:0], req_tuser, req_tlast,
                                 req_tdata[63:32], req_tdata[64]);
         if (csr_valid && csr_ready) tracker.apply_write(csr_index, csr_data);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // Response side: random stalls, plus one long hold-off on demand.
   initial begin : response_sink
      int unsigned stall = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            rsp_tready   <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = idle_gap();
         end
      end
   end

   initial begin : watchdog
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no request or response moved for %0d cycles", $time, stall_cycles);
      $display("end of test: mismatches");
      $finish;
   end

   // Offers one request and waits for it to be taken; valid stays high
   // unless a gap follows.
   task automatic send_reading(input bit [31:0] reading, input bit valid,
                               input bit last, input bit [TIME_W-1:0] now,
                               input bit link);
      int unsigned gap;
      req_tdata  <= {7'd0, link, now, reading};
      req_tuser  <= valid;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      phase_items++;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every response is in, then lets the block settle. The first
   // edge lets the monitor note a request taken at the edge just passed.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input bit [CSR_IDX_W-1:0] index,
                                 input bit [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all three registers and the unused index; spare bits are random.
   task automatic configure(input bit [31:0] deadband, input bit [31:0] heartbeat,
                            input bit zero_rule);
      write_register(REG_MIN_DELTA, deadband);
      write_register(REG_BEACON_TIMEOUT, heartbeat);
      write_register(REG_ZERO_FORCES, {31'($urandom), zero_rule});
      write_register(REG_UNUSED, $urandom);
      csr_valid <= 1'b0;
   endtask

   // One round of sensor requests. A well-formed round follows a drifting
   // level; the others carry no valid reading at all.
   task automatic run_round(input bit well_formed);
      int unsigned roll;
      int unsigned sensors;
      int          step;
      longint      noise;
      bit          last;
      if (!well_formed) begin
         sensors = $urandom_range(1, 4);
         for (int i = 0; i < sensors; i++)
            send_reading($urandom, 1'b0, i == sensors - 1, next_time(),
                         $urandom_range(0, 1));
         return;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         step = $urandom_range(0, 1024);
         level = level + step - 512;
      end else if (roll < 62) begin
         level = 0;
      end else if (roll < 75) begin
         level = int'($urandom);
      end else if (roll < 80) begin
         level = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
      end
      level = $signed(saturate(level));
      sensors = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
                                            : $urandom_range(1, 8);
      for (int i = 0; i < sensors; i++) begin
         noise = (level == 0) ? 0 : longint'($urandom_range(0, 6)) - 3;
         last  = (i == sensors - 1);
         send_reading(saturate(level + noise), $urandom_range(0, 99) < 85, last,
                      next_time(), $urandom_range(0, 99) < 85);
      end
   endtask

   initial begin : stimulus
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rounds at the reset setting.
      configure(32'd256, 32'd0, 1'b0);
      send_reading(32'h7FFF_FFFF, 1'b1, 1'b1, 32'd100, 1'b1);
      for (int i = 0; i < 4; i++)
         send_reading(32'h8000_0000, 1'b1, i == 3, 32'd200, 1'b1);
      // Nine valid sensors: the ninth is beyond the source limit.
      for (int i = 0; i < 8; i++)
         send_reading(32'd100, 1'b1, 1'b0, 32'd300, 1'b1);
      send_reading(32'h8000_0000, 1'b1, 1'b1, 32'd300, 1'b1);
      // A round with no valid reading forgets the report.
      send_reading(32'd5000, 1'b0, 1'b1, 32'd400, 1'b1);
      // Negative average truncated toward zero, first with the link down.
      send_reading(-3, 1'b1, 1'b0, 32'd500, 1'b1);
      send_reading(32'd0, 1'b1, 1'b1, 32'd500, 1'b0);
      send_reading(-3, 1'b1, 1'b0, 32'd600, 1'b1);
      send_reading(32'd0, 1'b1, 1'b1, 32'd600, 1'b1);
      // Change equal to the deadband, then one more.
      send_reading(32'd255, 1'b1, 1'b1, 32'd700, 1'b1);
      send_reading(32'd256, 1'b1, 1'b1, 32'hFFFF_FC00, 1'b1);
      wait_drained();

      // Widest deadband: only the drop-to-zero rule and the heartbeat fire,
      // the latter across the wrap of the millisecond clock.
      configure(32'hFFFF_FFFF, 32'd1000, 1'b1);
      send_reading(32'd0, 1'b1, 1'b1, 32'hFFFF_FD00, 1'b1);
      send_reading(32'd5, 1'b1, 1'b1, 32'h0000_00E8, 1'b1);
      send_reading(32'd5, 1'b1, 1'b1, 32'h0000_00E9, 1'b1);
      send_reading(32'd0, 1'b1, 1'b1, 32'h0000_0100, 1'b1);
      send_reading(32'd0, 1'b1, 1'b1, 32'h0000_0101, 1'b1);
      wait_drained();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(32'd0, 32'd0, 1'b1);
            1: configure(32'h7FFF_FFFF, 32'd1, 1'b0);
            2: configure($urandom_range(0, 2048), $urandom_range(200, 5000),
                         $urandom_range(0, 1));
            3: configure(32'd256, 32'hFFFF_FFFF, 1'b1);
            4: configure($urandom, $urandom, $urandom_range(0, 1));
            default: configure($urandom_range(0, 600), $urandom_range(0, 3000),
                               $urandom_range(0, 1));
         endcase
         idling_on = (phase != 0);
         // Back the block up while requests keep coming.
         if (phase == 2) hold_off_req <= 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) run_round($urandom_range(0, 9) != 0);
         wait_drained();
      end

      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
